// ----- hdl/bbd_pkg.sv -----
// Shared types and constants for the banked bus decoder with timer.
// No dependencies.
package bbd_pkg;

  localparam int WINDOW_BITS = 14;
  localparam int ADDR_W      = 16;
  localparam int PHYS_W      = 19;
  localparam int DATA_W      = 8;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    TGT_NONE     = 3'd0,
    TGT_RAM      = 3'd1,
    TGT_INTERNAL = 3'd2,
    TGT_DISCARD  = 3'd3,
    TGT_EXTERNAL = 3'd4
  } tgt_t;

  localparam logic [7:0] PAGE_IO  = 8'hFE;
  localparam logic [7:0] PAGE_TOP = 8'hFF;

  // Offsets within the I/O page
  localparam logic [7:0] OFS_BANK_LAST  = 8'h03;
  localparam logic [7:0] OFS_SER0_RD0   = 8'h10;
  localparam logic [7:0] OFS_SER0_RD1   = 8'h11;
  localparam logic [7:0] OFS_SER0_WR    = 8'h12;
  localparam logic [7:0] OFS_SER1_RD0   = 8'h18;
  localparam logic [7:0] OFS_SER1_RD1   = 8'h19;
  localparam logic [7:0] OFS_DISK_WR_LO = 8'h60;
  localparam logic [7:0] OFS_DISK_WR_HI = 8'h65;
  localparam logic [7:0] OFS_DISK_RD0   = 8'h65;
  localparam logic [7:0] OFS_DISK_RD1   = 8'h66;
  localparam logic [7:0] OFS_TMR_TARGET = 8'h80;
  localparam logic [7:0] OFS_TMR_RESET  = 8'h82;
  localparam logic [7:0] OFS_TMR_TRIG   = 8'h83;
  localparam logic [7:0] OFS_TMR_PAUSE  = 8'h84;
  localparam logic [7:0] OFS_TMR_CONT   = 8'h85;

  localparam logic [7:0] RD_UNKNOWN = 8'hFF;
  localparam logic [7:0] RD_ZERO    = 8'h00;

endpackage

// ----- hdl/banked_bus_decoder_with_timer.sv -----
// Banked bus decoder with 8-bit interval timer: top level.
// Depends on bbd_pkg.
//
// One beat in, one beat out; a new beat is taken every cycle while the output
// register is empty or being drained, so throughput is one access per clock;
// results show next cycle. Decode, bank lookup and timer update are a single pass
// of logic from the input ports and the bank/timer registers into the output
// register. Addresses below 0xFE00 go through four 16 KiB windows whose bank
// registers (reset 0..3) select a block of RAM; a block at or above RAM_BLOCKS
// is discarded (reads give 0xFF). 0xFF00..0xFFFF maps straight through. The
// I/O page 0xFE00..0xFEFF holds the bank registers, the timer, serial 1
// (reads 0) and forwards serial 0 and disk accesses outside. irq_level shows
// the interrupt request after the beat's own effect.
module banked_bus_decoder_with_timer
  import bbd_pkg::*;
#(
  parameter int RAM_BLOCKS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic [ADDR_W-1:0]     in_bus_address,
  input  logic [DATA_W-1:0]     in_write_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_target,
  output logic [PHYS_W-1:0]     out_physical_address,
  output logic [7:0]            out_io_offset,
  output logic [DATA_W-1:0]     out_read_data,
  output logic                  out_irq_level
);

  localparam int BLK_W = PHYS_W - WINDOW_BITS;

  logic [7:0]        window_block_r [4];
  logic [7:0]        window_block_nxt [4];
  logic [7:0]        timer_count_r, timer_count_nxt;
  logic [7:0]        timer_target_r, timer_target_nxt;
  logic              timer_running_r, timer_running_nxt;
  logic              irq_pending_r, irq_pending_nxt;

  logic              out_valid_r;
  tgt_t              target_r, target_nxt;
  logic [PHYS_W-1:0] phys_r, phys_nxt;
  logic [7:0]        ioff_r, ioff_nxt;
  logic [DATA_W-1:0] rdata_r, rdata_nxt;
  logic              irq_out_r;

  logic              accept;
  logic              is_write;
  logic [7:0]        page;
  logic [7:0]        ofs;
  logic [7:0]        block;
  logic              block_ok;
  logic              io_ext;
  logic [7:0]        count_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_write = (in_kind == KIND_WRITE);
  assign page     = in_bus_address[15:8];
  assign ofs      = in_bus_address[7:0];
  assign block    = window_block_r[in_bus_address[15:WINDOW_BITS]];
  assign block_ok = {1'b0, block} < 9'(RAM_BLOCKS);
  assign count_inc = timer_count_r + 8'd1;

  always_comb begin
    if (is_write) begin
      io_ext = (ofs == OFS_SER0_WR) || (ofs >= OFS_DISK_WR_LO && ofs <= OFS_DISK_WR_HI);
    end else begin
      io_ext = (ofs == OFS_SER0_RD0) || (ofs == OFS_SER0_RD1) ||
               (ofs == OFS_DISK_RD0) || (ofs == OFS_DISK_RD1);
    end
  end

  always_comb begin
    window_block_nxt  = window_block_r;
    timer_count_nxt   = timer_count_r;
    timer_target_nxt  = timer_target_r;
    timer_running_nxt = timer_running_r;
    irq_pending_nxt   = irq_pending_r;
    target_nxt        = TGT_NONE;
    phys_nxt          = '0;
    ioff_nxt          = '0;
    rdata_nxt         = '0;
    case (in_kind)
      KIND_TICK: begin
        if (timer_running_r) begin
          timer_count_nxt = count_inc;
          if (count_inc == timer_target_r) begin
            irq_pending_nxt   = 1'b1;
            timer_running_nxt = 1'b0;
          end
        end
      end
      KIND_READ, KIND_WRITE: begin
        if (page == PAGE_IO) begin
          if (io_ext) begin
            target_nxt = TGT_EXTERNAL;
            ioff_nxt   = ofs;
          end else begin
            target_nxt = TGT_INTERNAL;
            if (is_write) begin
              if (ofs <= OFS_BANK_LAST) begin
                window_block_nxt[ofs[1:0]] = in_write_data;
              end else begin
                case (ofs)
                  OFS_TMR_TARGET: begin
                    timer_target_nxt  = in_write_data;
                    irq_pending_nxt   = 1'b0;
                    timer_count_nxt   = '0;
                    timer_running_nxt = 1'b1;
                  end
                  OFS_TMR_RESET: begin
                    irq_pending_nxt   = 1'b0;
                    timer_count_nxt   = '0;
                    timer_running_nxt = 1'b1;
                  end
                  OFS_TMR_TRIG: begin
                    irq_pending_nxt = 1'b1;
                  end
                  OFS_TMR_PAUSE: begin
                    timer_running_nxt = 1'b0;
                  end
                  OFS_TMR_CONT: begin
                    timer_running_nxt = 1'b1;
                    irq_pending_nxt   = 1'b0;
                  end
                  default: begin
                  end
                endcase
              end
            end else if (ofs == OFS_SER1_RD0 || ofs == OFS_SER1_RD1) begin
              rdata_nxt = RD_ZERO;
            end else begin
              rdata_nxt = RD_UNKNOWN;
            end
          end
        end else if (page == PAGE_TOP) begin
          target_nxt = TGT_RAM;
          phys_nxt   = PHYS_W'(in_bus_address);
        end else if (block_ok) begin
          target_nxt = TGT_RAM;
          phys_nxt   = {block[BLK_W-1:0], in_bus_address[WINDOW_BITS-1:0]};
        end else begin
          target_nxt = TGT_DISCARD;
          rdata_nxt  = is_write ? RD_ZERO : RD_UNKNOWN;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_block_r[0] <= 8'd0;
      window_block_r[1] <= 8'd1;
      window_block_r[2] <= 8'd2;
      window_block_r[3] <= 8'd3;
      timer_count_r     <= '0;
      timer_target_r    <= '0;
      timer_running_r   <= 1'b0;
      irq_pending_r     <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (accept) begin
        window_block_r  <= window_block_nxt;
        timer_count_r   <= timer_count_nxt;
        timer_target_r  <= timer_target_nxt;
        timer_running_r <= timer_running_nxt;
        irq_pending_r   <= irq_pending_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      target_r  <= target_nxt;
      phys_r    <= phys_nxt;
      ioff_r    <= ioff_nxt;
      rdata_r   <= rdata_nxt;
      irq_out_r <= irq_pending_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_target           = target_r;
  assign out_physical_address = phys_r;
  assign out_io_offset        = ioff_r;
  assign out_read_data        = rdata_r;
  assign out_irq_level        = irq_out_r;

  a_ram_no_side_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && target_r == TGT_RAM |-> ioff_r == '0 && rdata_r == '0)
    else $error("RAM beat carries io_offset or read_data");

  a_phys_only_ram: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && target_r != TGT_RAM |-> phys_r == '0)
    else $error("physical address set on non-RAM beat");

  a_irq_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(!rst_n) && $past(accept) |-> irq_out_r == irq_pending_r)
    else $error("reported irq level differs from pending state");

  a_tick_keeps_banks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_kind == KIND_TICK |=>
      {window_block_r[0], window_block_r[1], window_block_r[2], window_block_r[3]} ==
      $past({window_block_r[0], window_block_r[1], window_block_r[2], window_block_r[3]}))
    else $error("tick changed a bank register");

  a_tick_irq_stops: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_kind == KIND_TICK && !irq_pending_r |=> !(irq_pending_r && timer_running_r))
    else $error("timer still running after tick raised irq");

endmodule

// ----- tb/sv/banked_bus_decoder_with_timer_test.sv -----
// Self-checking testbench for banked_bus_decoder_with_timer: drives bus reads, writes and
// timer ticks under random idling and back-pressure, and compares each result beat with
// a cycle-free model of the bank map and timer kept here. Depends on bbd_pkg and the RTL.
`timescale 1ns / 100ps

module banked_bus_decoder_with_timer_test;
  import bbd_pkg::*;

  localparam int RAM_BLOCKS = 32;
  localparam int IDLE_LIMIT = 1000;
  localparam int LONG_HOLD = 250;
  localparam int TOTAL_ACCESSES = 1450;
  localparam logic [1:0] KIND_NOP = 2'd3;

  localparam logic [7:0] IO_HOT [0:21] = '{
    8'h00, 8'h01, 8'h02, OFS_BANK_LAST, OFS_SER0_RD0, OFS_SER0_RD1, OFS_SER0_WR,
    OFS_SER1_RD0, OFS_SER1_RD1, OFS_DISK_WR_LO, 8'h62, OFS_DISK_WR_HI, OFS_DISK_RD1,
    OFS_TMR_TARGET, OFS_TMR_TARGET, 8'h81, OFS_TMR_RESET, OFS_TMR_TRIG, OFS_TMR_PAUSE,
    OFS_TMR_CONT, OFS_TMR_CONT, 8'h86
  };

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } bus_item_t;

  typedef struct packed {
    tgt_t              target;
    logic [PHYS_W-1:0] phys;
    logic [7:0]        ioff;
    logic [DATA_W-1:0] rdata;
    logic              irq;
  } bus_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = '0;
  logic [ADDR_W-1:0] in_bus_address = '0;
  logic [DATA_W-1:0] in_write_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_target;
  logic [PHYS_W-1:0] out_physical_address;
  logic [7:0] out_io_offset;
  logic [DATA_W-1:0] out_read_data;
  logic out_irq_level;

  banked_bus_decoder_with_timer #(.RAM_BLOCKS(RAM_BLOCKS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_bus_address(in_bus_address),
    .in_write_data(in_write_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_target(out_target),
    .out_physical_address(out_physical_address),
    .out_io_offset(out_io_offset),
    .out_read_data(out_read_data),
    .out_irq_level(out_irq_level)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // decoder state as seen by the accepted access stream
  logic [7:0] bank_map [4];
  logic [7:0] tmr_count;
  logic [7:0] tmr_target;
  logic tmr_running;
  logic irq_flag;

  bus_item_t queued_accesses[$];
  bus_result_t due_results[$];

  int accesses_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int n_ticks = 0;
  int n_discard = 0;
  int n_external = 0;
  int n_irq_high = 0;
  bit in_taken = 1'b0;

  function automatic bus_result_t decode_access(bus_item_t it);
    bus_result_t r;
    logic [7:0] blk;
    logic [7:0] ofs;
    logic wr;
    logic fwd;
    r = '0;
    ofs = it.addr[7:0];
    wr = (it.kind == KIND_WRITE);
    if (it.kind == KIND_TICK) begin
      if (tmr_running) begin
        tmr_count = tmr_count + 8'd1;
        if (tmr_count == tmr_target) begin
          irq_flag = 1'b1;
          tmr_running = 1'b0;
        end
      end
    end else if (it.kind == KIND_READ || wr) begin
      if (it.addr[15:8] == PAGE_IO) begin
        if (wr)
          fwd = (ofs == OFS_SER0_WR) || (ofs >= OFS_DISK_WR_LO && ofs <= OFS_DISK_WR_HI);
        else
          fwd = (ofs == OFS_SER0_RD0) || (ofs == OFS_SER0_RD1) ||
                (ofs == OFS_DISK_RD0) || (ofs == OFS_DISK_RD1);
        if (fwd) begin
          r.target = TGT_EXTERNAL;
          r.ioff = ofs;
        end else begin
          r.target = TGT_INTERNAL;
          if (!wr) begin
            r.rdata = (ofs == OFS_SER1_RD0 || ofs == OFS_SER1_RD1) ? RD_ZERO : RD_UNKNOWN;
          end else if (ofs <= OFS_BANK_LAST) begin
            bank_map[ofs[1:0]] = it.data;
          end else begin
            case (ofs)
              OFS_TMR_TARGET: begin
                tmr_target = it.data;
                irq_flag = 1'b0;
                tmr_count = '0;
                tmr_running = 1'b1;
              end
              OFS_TMR_RESET: begin
                irq_flag = 1'b0;
                tmr_count = '0;
                tmr_running = 1'b1;
              end
              OFS_TMR_TRIG: irq_flag = 1'b1;
              OFS_TMR_PAUSE: tmr_running = 1'b0;
              OFS_TMR_CONT: begin
                tmr_running = 1'b1;
                irq_flag = 1'b0;
              end
              default: ;
            endcase
          end
        end
      end else if (it.addr[15:8] == PAGE_TOP) begin
        r.target = TGT_RAM;
        r.phys = PHYS_W'(it.addr);
      end else begin
        blk = bank_map[it.addr[15:14]];
        if (blk < RAM_BLOCKS) begin
          r.target = TGT_RAM;
          r.phys = PHYS_W'((32'(blk) << WINDOW_BITS) | 32'(it.addr[WINDOW_BITS-1:0]));
        end else begin
          r.target = TGT_DISCARD;
          r.rdata = wr ? RD_ZERO : RD_UNKNOWN;
        end
      end
    end
    r.irq = irq_flag;
    return r;
  endfunction

  function automatic bus_item_t random_access();
    bus_item_t it;
    int pick;
    it.addr = 16'($urandom);
    it.data = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 24) begin
      it.kind = KIND_TICK;
    end else if (pick < 27) begin
      it.kind = KIND_NOP;
    end else begin
      it.kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
      pick = $urandom_range(0, 9);
      if (pick < 5)
        it.addr = 16'($urandom_range(0, 16'hFDFF));
      else if (pick < 6)
        it.addr = {PAGE_TOP, 8'($urandom)};
      else if (pick < 9)
        it.addr = {PAGE_IO, IO_HOT[$urandom_range(0, 21)]};
      else
        it.addr = {PAGE_IO, 8'($urandom)};
      if (it.kind == KIND_WRITE && it.addr[15:8] == PAGE_IO) begin
        if (it.addr[7:0] <= OFS_BANK_LAST && $urandom_range(0, 9) < 8)
          it.data = 8'($urandom_range(0, RAM_BLOCKS - 1));
        else if (it.addr[7:0] == OFS_TMR_TARGET && $urandom_range(0, 3) != 0)
          it.data = 8'($urandom_range(1, 12));
      end
    end
    return it;
  endfunction

  task automatic queue_access(logic [1:0] kind, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] data);
    queued_accesses.push_back('{kind: kind, addr: addr, data: data});
  endtask

  task automatic queue_random(int count);
    int t;
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        // program the timer, then tick it up to its target and sometimes past it
        t = $urandom_range(1, 10);
        queue_access(KIND_WRITE, {PAGE_IO, OFS_TMR_TARGET}, 8'(t));
        repeat (t + $urandom_range(0, 2)) queue_access(KIND_TICK, 16'($urandom), 8'($urandom));
        n += t + 1;
      end else begin
        queued_accesses.push_back(random_access());
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    while (queued_accesses.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  // sender: bursts of beats separated by random gaps
  int burst_left = 8;
  int gap_left = 0;
  always @(negedge clk) begin
    bus_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the offered beat
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (queued_accesses.size() > 0) begin
      it = queued_accesses.pop_front();
      in_valid <= 1'b1;
      in_kind <= it.kind;
      in_bus_address <= it.addr;
      in_write_data <= it.data;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: changing stall modes plus one long hold-off
  int hold_left = 0;
  int mode_left = 0;
  int ready_mode = 0;
  bit long_hold_done = 1'b0;
  always @(negedge clk) begin
    logic rdy;
    if (!rst_n) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      rdy = 1'b0;
      hold_left--;
    end else if (!long_hold_done && accesses_taken >= 300) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      rdy = 1'b0;
    end else begin
      if (mode_left <= 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (ready_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        default: rdy = ($urandom_range(0, 4) != 0);
      endcase
    end
    out_ready <= rdy;
  end

  always @(posedge clk) begin
    bus_result_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result beat tgt=%0d pa=%h io=%h rd=%h irq=%b", $realtime,
                     out_target, out_physical_address, out_io_offset, out_read_data,
                     out_irq_level);
        end else begin
          want = due_results.pop_front();
          if (out_target !== want.target || out_physical_address !== want.phys ||
              out_io_offset !== want.ioff || out_read_data !== want.rdata ||
              out_irq_level !== want.irq) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp tgt=%0d pa=%h io=%h rd=%h irq=%b,",
                       $realtime, want.target, want.phys, want.ioff, want.rdata, want.irq);
              $display("  got tgt=%0d pa=%h io=%h rd=%h irq=%b",
                       out_target, out_physical_address, out_io_offset, out_read_data,
                       out_irq_level);
            end
          end
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        want = decode_access('{kind: in_kind, addr: in_bus_address, data: in_write_data});
        due_results.push_back(want);
        accesses_taken++;
        if (in_kind == KIND_TICK) n_ticks++;
        if (want.target == TGT_DISCARD) n_discard++;
        if (want.target == TGT_EXTERNAL) n_external++;
        if (want.irq) n_irq_high++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $realtime, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int half;
    bank_map[0] = 8'd0;
    bank_map[1] = 8'd1;
    bank_map[2] = 8'd2;
    bank_map[3] = 8'd3;
    tmr_count = '0;
    tmr_target = '0;
    tmr_running = 1'b0;
    irq_flag = 1'b0;

    queue_access(KIND_READ, 16'h0000, 8'hFF);
    queue_access(KIND_WRITE, 16'hFDFF, 8'hA5);
    queue_access(KIND_READ, 16'hFFFF, 8'h00);
    queue_access(KIND_WRITE, {PAGE_TOP, 8'h00}, 8'h5A);
    queue_access(KIND_WRITE, {PAGE_IO, OFS_BANK_LAST}, 8'hFF);
    queue_access(KIND_READ, 16'hC123, 8'h00);
    queue_access(KIND_WRITE, 16'hC123, 8'h77);
    queue_access(KIND_WRITE, {PAGE_IO, 8'h00}, 8'(RAM_BLOCKS - 1));
    queue_access(KIND_READ, 16'h3FFF, 8'h00);
    queue_access(KIND_WRITE, {PAGE_IO, 8'h01}, 8'(RAM_BLOCKS));
    queue_access(KIND_READ, 16'h4000, 8'h00);
    queue_access(KIND_READ, {PAGE_IO, OFS_SER1_RD0}, 8'h00);
    queue_access(KIND_READ, {PAGE_IO, OFS_SER0_RD1}, 8'h00);
    queue_access(KIND_WRITE, {PAGE_IO, OFS_SER0_WR}, 8'h41);
    queue_access(KIND_READ, {PAGE_IO, OFS_DISK_RD1}, 8'h00);
    queue_access(KIND_WRITE, {PAGE_IO, OFS_DISK_WR_LO}, 8'h12);
    queue_access(KIND_READ, {PAGE_IO, OFS_TMR_TARGET}, 8'h00);
    queue_access(KIND_WRITE, {PAGE_IO, 8'h40}, 8'h33);
    queue_access(KIND_WRITE, {PAGE_IO, OFS_TMR_TARGET}, 8'd2);
    repeat (3) queue_access(KIND_TICK, 16'hFFFF, 8'hFF);
    queue_access(KIND_WRITE, {PAGE_IO, OFS_TMR_RESET}, 8'h00);
    queue_access(KIND_WRITE, {PAGE_IO, OFS_TMR_PAUSE}, 8'h00);
    queue_access(KIND_TICK, 16'h0000, 8'h00);
    queue_access(KIND_WRITE, {PAGE_IO, OFS_TMR_TRIG}, 8'h00);
    queue_access(KIND_WRITE, {PAGE_IO, OFS_TMR_CONT}, 8'h00);
    queue_access(KIND_NOP, 16'hFE83, 8'hFF);
    queue_access(KIND_WRITE, {PAGE_IO, 8'h01}, 8'd1);
    queue_access(KIND_WRITE, {PAGE_IO, OFS_BANK_LAST}, 8'd3);

    half = (TOTAL_ACCESSES - queued_accesses.size()) / 2;
    queue_random(half);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pause the sender until every result is back
    wait_drained();
    queue_random(TOTAL_ACCESSES - accesses_taken - half + half);
    wait_drained();
    repeat (10) @(posedge clk);

    if (due_results.size() != 0)
      mismatches++;
    $display("Ran %0d accesses: %0d timer ticks, %0d discarded, %0d forwarded to peripherals,",
             accesses_taken, n_ticks, n_discard, n_external);
    $display("%0d results checked, %0d carried the timer interrupt; %0d mismatches",
             results_seen, n_irq_high, mismatches);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
